>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

>>> src/tsort_pkg.sv
// ----------------------------------------------------------------------------
// tsort_pkg
// Request and result types and codes of the smallest-first topological order.
// ----------------------------------------------------------------------------
package tsort_pkg;

    localparam int NODE_W   = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int EDGE_W   = 2 * NODE_W;

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT     = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_GIVEN    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ALL_DONE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_CYCLE    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [STATUS_W-1:0] status;
        logic                edge_overflow;
    } out_item_t;

endpackage

>>> src/tsort_ram.sv
// ----------------------------------------------------------------------------
// tsort_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tsort_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> src/smallest_first_topological_order.sv
// ----------------------------------------------------------------------------
// smallest_first_topological_order
// Builds a directed graph edge by edge and gives its nodes in topological
// order, lowest-numbered ready node first.
// ----------------------------------------------------------------------------
// Clear completes when taken; add edge writes the edge memory and reads the
// target's in-degree, then writes it back raised by one. A next request
// scans nodes from 1 through the in-degree memory, one node per cycle,
// until the first ready node, marks it done in the same memory on the cycle
// it is found, then walks the edge memory one edge per cycle, pausing at each
// edge leaving the given node to lower its target's nonzero in-degree, and
// then loads the result once the output channel can take it. The in-degree
// and edge memories each have a single port. Each in-degree entry holds the
// node's done mark beside its count and carries a valid bit, so clear needs
// no sweep.
module smallest_first_topological_order #(
    parameter int MAX_NODES = 128,
    parameter int MAX_EDGES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tsort_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsort_pkg::out_item_t m_item
);

    localparam int NW  = tsort_pkg::NODE_W;
    localparam int NAW = $clog2(MAX_NODES);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ETW = $clog2(MAX_EDGES + 1);
    localparam int DW  = $clog2(MAX_EDGES + 1);
    localparam int RW  = DW + 1;

    localparam logic [NW-1:0]  MAXN = NW'(MAX_NODES);
    localparam logic [ETW-1:0] MAXE = ETW'(MAX_EDGES);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ADD_WR = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_DEG_WR = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [NW-1:0]               node_count_reg;
    logic [ETW-1:0]              edge_total_reg, edge_total_next;
    logic                        overflow_reg, overflow_next;
    logic [MAX_NODES-1:0]        deg_vld_reg, deg_vld_next;
    logic [NW:0]                 issue_idx_reg, issue_idx_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [NW-1:0]               chk_idx_reg, chk_idx_next;
    logic                        remain_reg, remain_next;
    logic [ETW-1:0]              walk_idx_reg, walk_idx_next;
    logic                        wchk_valid_reg, wchk_valid_next;
    logic [ETW-1:0]              wchk_idx_reg, wchk_idx_next;
    logic [NW-1:0]               upd_node_reg, upd_node_next;
    logic [NW-1:0]               res_node_reg, res_node_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic                        m_valid_reg, m_valid_next;
    tsort_pkg::out_item_t        m_item_reg, m_item_next;

    logic                        e_we;
    logic [EAW-1:0]              e_addr;
    logic [tsort_pkg::EDGE_W-1:0] e_wdata, e_rdata;
    logic                        d_we;
    logic [NAW-1:0]              d_addr;
    logic [RW-1:0]               d_wdata, d_rdata;

    logic [NW-1:0]               n_active;
    logic [NW-1:0]               chk_off, upd_off, issue_off, dst_off, edst_off;
    logic [NAW-1:0]              chk_addr, upd_addr;
    logic [RW-1:0]               chk_entry, upd_entry;
    logic                        chk_done, upd_done;
    logic [DW-1:0]               chk_deg, upd_deg;
    logic [NW-1:0]               e_src, e_dst;
    logic                        bad_edge;

    tsort_ram #(.WIDTH(tsort_pkg::EDGE_W), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .aclk  (aclk),
        .we    (e_we),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    tsort_ram #(.WIDTH(RW), .DEPTH(MAX_NODES), .AW(NAW)) u_deg_ram (
        .aclk  (aclk),
        .we    (d_we),
        .addr  (d_addr),
        .wdata (d_wdata),
        .rdata (d_rdata)
    );

    assign n_active  = (node_count_reg > MAXN) ? MAXN : node_count_reg;
    assign chk_off   = chk_idx_reg - NW'(1);
    assign upd_off   = upd_node_reg - NW'(1);
    assign issue_off = issue_idx_reg[NW-1:0] - NW'(1);
    assign dst_off   = s_item.to_node - NW'(1);
    assign e_src     = e_rdata[tsort_pkg::EDGE_W-1:NW];
    assign e_dst     = e_rdata[NW-1:0];
    assign edst_off  = e_dst - NW'(1);
    assign chk_addr  = chk_off[NAW-1:0];
    assign upd_addr  = upd_off[NAW-1:0];
    assign chk_entry = deg_vld_reg[chk_addr] ? d_rdata : '0;
    assign upd_entry = deg_vld_reg[upd_addr] ? d_rdata : '0;
    assign chk_done  = chk_entry[DW];
    assign chk_deg   = chk_entry[DW-1:0];
    assign upd_done  = upd_entry[DW];
    assign upd_deg   = upd_entry[DW-1:0];
    assign bad_edge  = (s_item.from_node == '0) || (s_item.from_node > MAXN) ||
                       (s_item.to_node == '0) || (s_item.to_node > MAXN);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next      = state_reg;
        edge_total_next = edge_total_reg;
        overflow_next   = overflow_reg;
        deg_vld_next    = deg_vld_reg;
        issue_idx_next  = issue_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        remain_next     = remain_reg;
        walk_idx_next   = walk_idx_reg;
        wchk_valid_next = wchk_valid_reg;
        wchk_idx_next   = wchk_idx_reg;
        upd_node_next   = upd_node_reg;
        res_node_next   = res_node_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        e_we            = 1'b0;
        e_addr          = walk_idx_reg[EAW-1:0];
        e_wdata         = {s_item.from_node, s_item.to_node};
        d_we            = 1'b0;
        d_addr          = upd_addr;
        d_wdata         = {upd_done, upd_deg + DW'(1)};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_item.operation)
                        tsort_pkg::OP_CLEAR: begin
                            edge_total_next = '0;
                            overflow_next   = 1'b0;
                            deg_vld_next    = '0;
                        end
                        tsort_pkg::OP_ADD_EDGE: begin
                            if (!bad_edge) begin
                                if (edge_total_reg >= MAXE) begin
                                    overflow_next = 1'b1;
                                end else begin
                                    e_we            = 1'b1;
                                    e_addr          = edge_total_reg[EAW-1:0];
                                    edge_total_next = edge_total_reg + ETW'(1);
                                    d_addr          = dst_off[NAW-1:0];
                                    upd_node_next   = s_item.to_node;
                                    state_next      = ST_ADD_WR;
                                end
                            end
                        end
                        tsort_pkg::OP_NEXT: begin
                            if (n_active == '0) begin
                                res_node_next   = '0;
                                res_status_next = tsort_pkg::STAT_ALL_DONE;
                                state_next      = ST_RESP;
                            end else begin
                                issue_idx_next = (NW+1)'(1);
                                chk_valid_next = 1'b0;
                                remain_next    = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_WR: begin
                d_we                   = 1'b1;
                d_wdata                = {upd_done, upd_deg + DW'(1)};
                deg_vld_next[upd_addr] = 1'b1;
                state_next             = ST_IDLE;
            end
            ST_SCAN: begin
                if (issue_idx_reg <= {1'b0, n_active}) begin
                    d_addr         = issue_off[NAW-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_idx_reg[NW-1:0];
                    issue_idx_next = issue_idx_reg + (NW+1)'(1);
                end else begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg) begin
                    if (!chk_done) begin
                        remain_next = 1'b1;
                        if (chk_deg == '0) begin
                            d_we                   = 1'b1;
                            d_addr                 = chk_addr;
                            d_wdata                = {1'b1, chk_deg};
                            deg_vld_next[chk_addr] = 1'b1;
                            res_node_next          = chk_idx_reg;
                            res_status_next        = tsort_pkg::STAT_GIVEN;
                            walk_idx_next          = '0;
                            wchk_valid_next        = 1'b0;
                            state_next = (edge_total_reg != '0) ? ST_WALK : ST_RESP;
                        end
                    end
                end else if (issue_idx_reg > {1'b0, n_active}) begin
                    res_node_next   = '0;
                    res_status_next = remain_reg ? tsort_pkg::STAT_CYCLE
                                                 : tsort_pkg::STAT_ALL_DONE;
                    state_next      = ST_RESP;
                end
            end
            ST_WALK: begin
                if (walk_idx_reg < edge_total_reg) begin
                    e_addr          = walk_idx_reg[EAW-1:0];
                    wchk_valid_next = 1'b1;
                    wchk_idx_next   = walk_idx_reg;
                    walk_idx_next   = walk_idx_reg + ETW'(1);
                end else begin
                    wchk_valid_next = 1'b0;
                end
                if (wchk_valid_reg && (e_src == res_node_reg)) begin
                    d_addr          = edst_off[NAW-1:0];
                    upd_node_next   = e_dst;
                    walk_idx_next   = wchk_idx_reg + ETW'(1);
                    wchk_valid_next = 1'b0;
                    state_next      = ST_DEG_WR;
                end else if (!wchk_valid_reg && (walk_idx_reg >= edge_total_reg)) begin
                    state_next = ST_RESP;
                end
            end
            ST_DEG_WR: begin
                d_we       = (upd_deg != '0);
                d_wdata    = {upd_done, upd_deg - DW'(1)};
                state_next = ST_WALK;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_item_next.node          = res_node_reg;
                    m_item_next.status        = res_status_reg;
                    m_item_next.edge_overflow = overflow_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= NW'(1);
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            deg_vld_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            wchk_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            overflow_reg   <= overflow_next;
            deg_vld_reg    <= deg_vld_next;
            chk_valid_reg  <= chk_valid_next;
            wchk_valid_reg <= wchk_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_idx_reg  <= issue_idx_next;
        chk_idx_reg    <= chk_idx_next;
        remain_reg     <= remain_next;
        walk_idx_reg   <= walk_idx_next;
        wchk_idx_reg   <= wchk_idx_next;
        upd_node_reg   <= upd_node_next;
        res_node_reg   <= res_node_next;
        res_status_reg <= res_status_next;
        m_item_reg     <= m_item_next;
    end

endmodule

>>> src/tsort_checker.sv
// ----------------------------------------------------------------------------
// tsort_checker
// Port-level assertions for the smallest-first topological order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsort_checker #(
    parameter int MAX_NODES = 128
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input tsort_pkg::in_item_t  s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input tsort_pkg::out_item_t m_item
);

    localparam int NW = tsort_pkg::NODE_W;

    localparam logic [NW-1:0] MAXN = NW'(MAX_NODES);

    logic given;
    logic next_req;
    logic node_in_range;

    assign given         = m_valid && (m_item.status == tsort_pkg::STAT_GIVEN);
    assign next_req      = s_valid && s_ready && (s_item.operation == tsort_pkg::OP_NEXT);
    assign node_in_range = (m_item.node != '0) && (m_item.node <= MAXN);

    // hold a stalled result
    `ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    // a given node lies in the node range
    `ASSERT_IMPLY(a_given_range, aclk, aresetn, given, node_in_range)
    // no node without a given status
    `ASSERT_IMPLY(a_none_zero, aclk, aresetn, m_valid && !given, m_item.node == '0)
    // a next request leaves the block not ready in the following cycle
    `ASSERT_NEXT(a_next_busy, aclk, aresetn, next_req, !s_ready)

endmodule

bind smallest_first_topological_order tsort_checker #(.MAX_NODES(MAX_NODES)) u_tsort_checker (.*);

>>> tb/tb_smallest_first_topological_order.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smallest_first_topological_order
// Self-checking bench for the smallest-first topological order block. A queue
// of graph requests (clear, add edge, next node and unused codes) feeds a
// valid/ready driver. Accepted requests update a local graph predictor that
// queues the expected order results. A monitor compares each result field by
// field. Phases vary the node count register and the idling on both channels.
// One phase holds off the result channel for a long stretch.
// ----------------------------------------------------------------------------
module tb_smallest_first_topological_order;

    localparam int MAX_NODES     = 128;
    localparam int MAX_EDGES     = 256;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int OPW           = tsort_pkg::OP_W;
    localparam int NW            = tsort_pkg::NODE_W;

    localparam logic [OPW-1:0] OP_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [7:0]           cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    tsort_pkg::in_item_t  s_item;
    logic                 m_valid;
    logic                 m_ready;
    tsort_pkg::out_item_t m_item;

    tsort_pkg::in_item_t  req_queue [$];
    tsort_pkg::out_item_t expected_order [$];

    int edge_from [MAX_EDGES];
    int edge_to   [MAX_EDGES];
    int edge_cnt;
    int in_deg    [MAX_NODES+1];
    bit finished  [MAX_NODES+1];
    bit dropped_edge;
    int node_limit;

    int          n_errors = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_len = 0;
    int unsigned cycle_count = 0;

    smallest_first_topological_order #(
        .MAX_NODES(MAX_NODES),
        .MAX_EDGES(MAX_EDGES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

    always #5 aclk = ~aclk;

    function automatic void wipe_graph();
        edge_cnt = 0;
        dropped_edge = 1'b0;
        foreach (in_deg[i]) begin
            in_deg[i] = 0;
            finished[i] = 1'b0;
        end
    endfunction

    function automatic void advance_graph(input tsort_pkg::in_item_t req);
        int                   scan_end;
        int                   pick;
        int                   i;
        int                   a;
        int                   b;
        bit                   pending;
        tsort_pkg::out_item_t res;
        a = req.from_node;
        b = req.to_node;
        scan_end = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
        pick = 0;
        pending = 1'b0;
        case (req.operation)
            tsort_pkg::OP_CLEAR: begin
                wipe_graph();
            end
            tsort_pkg::OP_ADD_EDGE: begin
                if (a != 0 && a <= MAX_NODES && b != 0 && b <= MAX_NODES) begin
                    if (edge_cnt >= MAX_EDGES) begin
                        dropped_edge = 1'b1;
                    end else begin
                        edge_from[edge_cnt] = a;
                        edge_to[edge_cnt] = b;
                        edge_cnt++;
                        in_deg[b]++;
                    end
                end
            end
            tsort_pkg::OP_NEXT: begin
                for (i = 1; i <= scan_end && pick == 0; i++) begin
                    if (!finished[i]) begin
                        pending = 1'b1;
                        if (in_deg[i] == 0) pick = i;
                    end
                end
                if (pick != 0) begin
                    finished[pick] = 1'b1;
                    for (i = 0; i < edge_cnt; i++) begin
                        if (edge_from[i] == pick && in_deg[edge_to[i]] > 0)
                            in_deg[edge_to[i]]--;
                    end
                end
                res.node = pick[NW-1:0];
                res.status = (pick != 0) ? tsort_pkg::STAT_GIVEN :
                             (pending ? tsort_pkg::STAT_CYCLE : tsort_pkg::STAT_ALL_DONE);
                res.edge_overflow = dropped_edge;
                expected_order.insert(expected_order.size(), res);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic push_req(input logic [OPW-1:0] op, input int a, input int b);
        tsort_pkg::in_item_t r;
        r.operation = op;
        r.from_node = a[NW-1:0];
        r.to_node = b[NW-1:0];
        req_queue.insert(req_queue.size(), r);
    endtask

    // clear, a random DAG over n nodes, an optional stray edge, then enough next requests to finish
    task automatic push_round(input int n, input int n_edges, input bit with_loop);
        int rank [MAX_NODES+1];
        int i;
        int j;
        int k;
        int tmp;
        for (i = 1; i <= n; i++) rank[i] = i;
        for (i = n; i > 1; i--) begin
            j = $urandom_range(i, 1);
            tmp = rank[i];
            rank[i] = rank[j];
            rank[j] = tmp;
        end
        push_req(tsort_pkg::OP_CLEAR, $urandom_range(255), $urandom_range(255));
        for (k = 0; k < n_edges; k++) begin
            i = $urandom_range(n - 1, 1);
            j = $urandom_range(n, i + 1);
            push_req(tsort_pkg::OP_ADD_EDGE, rank[i], rank[j]);
            if ($urandom_range(15) == 0)
                push_req(tsort_pkg::OP_NEXT, $urandom_range(255), $urandom_range(255));
        end
        if (with_loop)
            push_req(tsort_pkg::OP_ADD_EDGE, $urandom_range(n, 1), $urandom_range(n, 1));
        for (k = 0; k <= n; k++)
            push_req(tsort_pkg::OP_NEXT, $urandom_range(255), $urandom_range(255));
    endtask

    task automatic push_noise(input int count);
        int k;
        for (k = 0; k < count; k++)
            push_req(OPW'($urandom_range(3)), $urandom_range(255), $urandom_range(255));
    endtask

    // sample away from the driving edge so that launched requests are seen
    task automatic drain();
        @(negedge aclk);
        while (req_queue.size() != 0 || s_valid || expected_order.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge aclk);
        send_idle_pct <= send_pct;
        stall_pct <= recv_pct;
    endtask

    task automatic write_node_count(input int value);
        drain();
        while (!s_ready) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value[7:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        node_limit = value;
    endtask

    always @(posedge aclk) begin : request_drive
        logic accepted;
        accepted = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (accepted) advance_graph(s_item);
            if (!s_valid || accepted) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item <= req_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_len > 0) begin
            m_ready <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        tsort_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_order.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result node=%0d status=%0d overflow=%0d",
                         $time, m_item.node, m_item.status, m_item.edge_overflow);
            end else begin
                want = expected_order.pop_front();
                if (m_item.node !== want.node) begin
                    n_errors++;
                    $display("%0t: node expected %0d actual %0d",
                             $time, want.node, m_item.node);
                end
                if (m_item.status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_item.status);
                end
                if (m_item.edge_overflow !== want.edge_overflow) begin
                    n_errors++;
                    $display("%0t: edge_overflow expected %0d actual %0d",
                             $time, want.edge_overflow, m_item.edge_overflow);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        wipe_graph();
        node_limit = 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: ignored edges, self loop, edge from a node above the count
        write_node_count(5);
        push_req(tsort_pkg::OP_ADD_EDGE, 5, 1);
        push_req(tsort_pkg::OP_ADD_EDGE, 4, 1);
        push_req(tsort_pkg::OP_ADD_EDGE, 3, 3);
        push_req(tsort_pkg::OP_ADD_EDGE, 0, 2);
        push_req(tsort_pkg::OP_ADD_EDGE, 2, 255);
        push_req(tsort_pkg::OP_ADD_EDGE, 129, 2);
        push_req(tsort_pkg::OP_ADD_EDGE, 128, 2);
        push_req(OP_UNUSED, 255, 255);
        repeat (4) push_req(tsort_pkg::OP_NEXT, 0, 0);
        push_req(tsort_pkg::OP_CLEAR, 255, 255);
        repeat (6) push_req(tsort_pkg::OP_NEXT, 255, 255);
        drain();

        write_node_count(8);
        push_round(8, 14, 1'b1);
        push_noise(6);

        write_node_count(1);
        set_idling(73, 0);
        push_round(3, 3, 1'b1);
        push_noise(8);
        push_round(2, 1, 1'b0);

        write_node_count(16);
        set_idling(0, 73);
        push_round(12, 14, 1'b0);
        push_round(10, 10, 1'b1);

        write_node_count(0);
        set_idling(34, 34);
        push_noise(6);
        push_round(4, 4, 1'b0);

        // fill the edge store past capacity, then clear the sticky flag
        write_node_count(255);
        set_idling(34, 34);
        push_round(12, MAX_EDGES + 2, 1'b0);
        push_req(tsort_pkg::OP_CLEAR, 0, 0);
        push_req(tsort_pkg::OP_NEXT, 0, 0);

        // hold off results while requests keep coming, then drain and stall the result channel at random
        write_node_count(MAX_NODES);
        set_idling(0, 0);
        push_round(6, 8, 1'b1);
        push_noise(6);
        hold_len <= 300;
        drain();
        set_idling(0, 34);
        push_round(5, 6, 1'b0);

        write_node_count(1);
        push_round(2, 1, 1'b1);

        drain();
        repeat (40) @(posedge aclk);
        if (n_errors == 0 && expected_order.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
